// ----- rtl/core/lit_triangle_rasterizer_assert.svh -----
// assertion helpers for the rasterizer core
`ifndef LIT_TRIANGLE_RASTERIZER_ASSERT_SVH
`define LIT_TRIANGLE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define LTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lit_triangle_rasterizer assertion failed");
`define LTR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lit_triangle_rasterizer assertion failed");
`else
`define LTR_ASSERT_IMP(lbl, ante, cons)
`define LTR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/ltr_pkg.sv -----
`default_nettype none

package ltr_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd800;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd600;

  localparam logic [7:0] SHADE_MAX = 8'hFF;
  localparam logic [3:0] MUL_LAST  = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } ltr_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_INIT,
    DIV_RUN,
    DIV_DONE
  } ltr_div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ltr_div_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ltr_shade_div.sv -----
`default_nettype none

`include "lit_triangle_rasterizer_assert.svh"

module ltr_shade_div #(
  parameter int FRAC_BITS = 4,
  parameter int QW = 39
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [23:0]            strength,
  input  wire logic [QW-1:0]          dist_sq,
  output ltr_pkg::ltr_div_status_t    status,
  output logic [7:0]                  shade
);
  import ltr_pkg::*;

  localparam int NW   = 24 + 2 * FRAC_BITS;
  localparam int DENW = QW + 8;
  localparam int RW   = NW + 8;
  localparam int SW   = DENW + 7;

  ltr_div_state_t state, state_next;

  logic [NW-1:0]   num_r;
  logic [DENW-1:0] den_r;
  logic [RW-1:0]   rem;
  logic [SW-1:0]   dsh;
  logic [7:0]      quo;
  logic [2:0]      cnt;
  logic            sat_r;
  logic            ge;

  // one compare and subtract per quotient bit
  assign ge = SW'(rem) >= dsh;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_INIT;
      DIV_INIT: state_next = DIV_RUN;
      DIV_RUN:  if (cnt == 3'd7) state_next = DIV_DONE;
      DIV_DONE: state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state != DIV_IDLE);
    status.done = (state == DIV_DONE);
    shade       = sat_r ? SHADE_MAX : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        if (start) begin
          num_r <= NW'(strength) << (2 * FRAC_BITS);
          den_r <= DENW'(dist_sq) << 8;
        end
      end
      DIV_INIT: begin
        sat_r <= (den_r == '0) || (DENW'(num_r) >= den_r);
        // dividend is 255 * num
        rem   <= (RW'(num_r) << 8) - RW'(num_r);
        dsh   <= SW'(den_r) << 7;
        cnt   <= '0;
        quo   <= '0;
      end
      DIV_RUN: begin
        if (ge) begin
          rem <= rem - RW'(dsh);
        end
        quo <= {quo[6:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt + 3'd1;
      end
      default: begin
      end
    endcase
  end

  `LTR_ASSERT_IMP(a_start_when_idle, start, state == DIV_IDLE)
  `LTR_ASSERT_IMP(a_quo_below_max, state == DIV_DONE && !sat_r, quo != SHADE_MAX)
  `LTR_ASSERT_NXT(a_init_to_run, state == DIV_INIT, state == DIV_RUN && cnt == 3'd0)

endmodule

`default_nettype wire

// ----- rtl/core/lit_triangle_rasterizer.sv -----
// load item: no result, the block stays idle, next item the cycle after
// tick on an idle scan: straight to the done state, no multiply or divide
// tick on a pixel outside or off screen: result after the MUL state, set by the
//   eight products of the shared multiplier plus one accumulate
// tick on a lit pixel: result after the MUL state and the 8-bit serial divider
// next item in the cycle after each result is loaded; sync reset: scan idle, 800 x 600
`default_nettype none

`include "lit_triangle_rasterizer_assert.svh"

module lit_triangle_rasterizer #(
  parameter int MAX_SCREEN = 4096,
  parameter int FRAC_BITS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [12:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic signed [15:0] vertex_a_x,
  input  wire logic signed [15:0] vertex_a_y,
  input  wire logic signed [15:0] vertex_b_x,
  input  wire logic signed [15:0] vertex_b_y,
  input  wire logic signed [15:0] light_x,
  input  wire logic signed [15:0] light_y,
  input  wire logic [12:0]        box_min_x,
  input  wire logic [12:0]        box_max_x,
  input  wire logic [12:0]        box_min_y,
  input  wire logic [12:0]        box_max_y,
  input  wire logic [23:0]        light_strength,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    write_enable,
  output logic [11:0]             pixel_x,
  output logic [11:0]             pixel_y,
  output logic [31:0]             pixel_color,
  output logic                    done_res
);
  import ltr_pkg::*;

  localparam int PXW = 14 + FRAC_BITS;
  localparam int DW  = (PXW > 16 ? PXW : 16) + 1;
  localparam int MW  = 2 * DW;
  localparam int AW  = MW + 1;
  localparam logic [13:0] MAX_SCR = 14'(MAX_SCREEN);

  ltr_state_t state, state_next;

  logic [12:0] screen_width, screen_height;

  logic signed [15:0] ax, ay, bx, by, cx, cy;
  logic [12:0] max_x, min_y, max_y;
  logic [23:0] strength;
  logic [12:0] scan_col, scan_row;
  logic        active;

  logic [12:0] cur_col, cur_row;
  logic        cur_on, cur_last, in_tri;
  logic [3:0]  step;

  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e, px_e, py_e;
  logic signed [DW-1:0] u1, u2, w1, w2, op_a, op_b;
  logic signed [MW-1:0] prod_r;
  logic signed [AW-1:0] acc, acc_alu, prod_ext;
  logic [2:0]  prev;
  logic        acc_sub;

  logic        accept, out_load, div_start, hit, on_now;
  logic [13:0] row_inc, col_inc;

  ltr_div_status_t div_status;
  logic [7:0]      div_shade;

  assign accept = in_valid && in_ready;
  assign hit    = in_tri && cur_on;

  assign on_now = ({1'b0, scan_col} < {1'b0, screen_width}) &&
                  ({1'b0, scan_col} < MAX_SCR) &&
                  ({1'b0, scan_row} < {1'b0, screen_height}) &&
                  ({1'b0, scan_row} < MAX_SCR);
  assign row_inc = {1'b0, scan_row} + 14'd1;
  assign col_inc = {1'b0, scan_col} + 14'd1;

  // operand extension to the multiplier width
  assign ax_e = {{(DW-16){ax[15]}}, ax};
  assign ay_e = {{(DW-16){ay[15]}}, ay};
  assign bx_e = {{(DW-16){bx[15]}}, bx};
  assign by_e = {{(DW-16){by[15]}}, by};
  assign cx_e = {{(DW-16){cx[15]}}, cx};
  assign cy_e = {{(DW-16){cy[15]}}, cy};
  assign px_e = $signed(DW'(cur_col) << FRAC_BITS);
  assign py_e = $signed(DW'(cur_row) << FRAC_BITS);

  // edge terms in pairs, then the two squared distance terms
  always_comb begin
    unique case (step[2:0])
      3'd0: begin u1 = cx_e; u2 = bx_e; w1 = py_e; w2 = by_e; end
      3'd1: begin u1 = cy_e; u2 = by_e; w1 = px_e; w2 = bx_e; end
      3'd2: begin u1 = ax_e; u2 = cx_e; w1 = py_e; w2 = cy_e; end
      3'd3: begin u1 = ay_e; u2 = cy_e; w1 = px_e; w2 = cx_e; end
      3'd4: begin u1 = bx_e; u2 = ax_e; w1 = py_e; w2 = ay_e; end
      3'd5: begin u1 = by_e; u2 = ay_e; w1 = px_e; w2 = ax_e; end
      3'd6: begin u1 = cx_e; u2 = px_e; w1 = cx_e; w2 = px_e; end
      3'd7: begin u1 = cy_e; u2 = py_e; w1 = cy_e; w2 = py_e; end
      default: begin u1 = '0; u2 = '0; w1 = '0; w2 = '0; end
    endcase
    op_a = u1 - u2;
    op_b = w1 - w2;
  end

  assign prev     = step[2:0] - 3'd1;
  assign acc_sub  = prev[0] && (prev != 3'd7);
  assign prod_ext = {prod_r[MW-1], prod_r};
  assign acc_alu  = acc_sub ? (acc - prod_ext) : (acc + prod_ext);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_TICK) begin
            state_next = active ? ST_MUL : ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (step == MUL_LAST) begin
          state_next = (in_tri && cur_on) ? ST_DIV_GO : ST_DONE;
        end
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_status.done) state_next = ST_DONE;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_DONE:   out_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
      endcase
    end
  end

  // control and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      active    <= 1'b0;
      scan_col  <= '0;
      scan_row  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) begin
        step <= step + 4'd1;
      end
      if (accept) begin
        step <= '0;
        if (opcode == OP_LOAD) begin
          scan_col <= box_min_x;
          scan_row <= box_min_y;
          active   <= (box_min_x < box_max_x) && (box_min_y < box_max_y);
        end else if (active) begin
          if (row_inc >= {1'b0, max_y}) begin
            scan_row <= min_y;
            scan_col <= col_inc[12:0];
            if (col_inc >= {1'b0, max_x}) begin
              active <= 1'b0;
            end
          end else begin
            scan_row <= row_inc[12:0];
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // triangle, box and pixel under test
  always_ff @(posedge clk) begin
    if (accept) begin
      if (opcode == OP_LOAD) begin
        ax       <= vertex_a_x;
        ay       <= vertex_a_y;
        bx       <= vertex_b_x;
        by       <= vertex_b_y;
        cx       <= light_x;
        cy       <= light_y;
        max_x    <= box_max_x;
        min_y    <= box_min_y;
        max_y    <= box_max_y;
        strength <= light_strength;
      end else if (active) begin
        cur_col  <= scan_col;
        cur_row  <= scan_row;
        cur_on   <= on_now;
        cur_last <= (row_inc >= {1'b0, max_y}) && (col_inc >= {1'b0, max_x});
        in_tri   <= 1'b1;
      end else begin
        cur_col  <= '0;
        cur_row  <= '0;
        cur_on   <= 1'b0;
        cur_last <= 1'b1;
        in_tri   <= 1'b0;
      end
    end else if (state == ST_MUL && step != '0 && acc_sub) begin
      in_tri <= in_tri & ~acc_alu[AW-1];
    end
  end

  // shared multiplier and accumulator
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (state == ST_MUL && step != '0) begin
      unique case (prev)
        3'd0, 3'd2, 3'd4, 3'd6: acc <= prod_ext;
        3'd1, 3'd3, 3'd5: begin
        end
        3'd7:                   acc <= acc_alu;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      write_enable <= hit;
      pixel_x      <= cur_col[11:0];
      pixel_y      <= cur_row[11:0];
      pixel_color  <= hit ? {4{div_shade}} : '0;
      done_res     <= cur_last;
    end
  end

  ltr_shade_div #(
    .FRAC_BITS(FRAC_BITS),
    .QW(AW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .strength(strength),
    .dist_sq($unsigned(acc)),
    .status(div_status),
    .shade(div_shade)
  );

  `LTR_ASSERT_IMP(a_div_only_on_hit, state == ST_DIV_WAIT, in_tri && cur_on)
  `LTR_ASSERT_NXT(a_idle_tick_last, accept && opcode == OP_TICK && !active, state == ST_DONE && cur_last)
  `LTR_ASSERT_NXT(a_out_loaded, out_load, out_valid)
  `LTR_ASSERT_IMP(a_miss_no_color, out_valid && !write_enable, pixel_color == 32'd0)

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;
  import ltr_pkg::*;

  localparam int FRAC = 4;
  localparam int MAX_SCREEN = 4096;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic        op;
    logic [15:0] ax, ay, bx, by, cx, cy;
    logic [12:0] min_x, max_x, min_y, max_y;
    logic [23:0] strength;
  } raster_item_t;

  typedef struct packed {
    logic        we;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
    logic        done;
  } pixel_result_t;

  typedef struct packed {
    raster_item_t  item;
    logic          typed;
    pixel_result_t want;
  } plan_row_t;

  localparam pixel_result_t IDLE_TICK = '{1'b0, 12'd0, 12'd0, 32'd0, 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_SCREEN_WIDTH;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_LOAD;
  logic [15:0] vertex_a_x = '0, vertex_a_y = '0, vertex_b_x = '0, vertex_b_y = '0;
  logic [15:0] light_x = '0, light_y = '0;
  logic [12:0] box_min_x = '0, box_max_x = '0, box_min_y = '0, box_max_y = '0;
  logic [23:0] light_strength = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic write_enable;
  logic [11:0] pixel_x, pixel_y;
  logic [31:0] pixel_color;
  logic done_res;

  lit_triangle_rasterizer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y),
    .vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y),
    .light_x(light_x), .light_y(light_y),
    .box_min_x(box_min_x), .box_max_x(box_max_x),
    .box_min_y(box_min_y), .box_max_y(box_max_y),
    .light_strength(light_strength),
    .out_valid(out_valid), .out_ready(out_ready),
    .write_enable(write_enable), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_color(pixel_color), .done_res(done_res)
  );

  always #6 clk = ~clk;

  // scan state mirrored from the block
  logic [12:0] scr_w, scr_h;
  longint tri_v [6];
  logic [12:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  logic [23:0] glow;
  logic [12:0] scan_col, scan_row;
  logic scan_on;

  pixel_result_t pending_pixels [$];
  int mismatches = 0;
  int cycle = 0;
  int n_loads = 0, n_ticks = 0, n_lit = 0, n_settings = 1;
  bit no_stall = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic longint edge_side(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic void load_triangle(raster_item_t it);
    tri_v[0] = longint'($signed(it.ax));
    tri_v[1] = longint'($signed(it.ay));
    tri_v[2] = longint'($signed(it.bx));
    tri_v[3] = longint'($signed(it.by));
    tri_v[4] = longint'($signed(it.cx));
    tri_v[5] = longint'($signed(it.cy));
    box_lo_x = it.min_x;
    box_hi_x = it.max_x;
    box_lo_y = it.min_y;
    box_hi_y = it.max_y;
    glow = it.strength;
    scan_col = it.min_x;
    scan_row = it.min_y;
    scan_on = (it.min_x < it.max_x) && (it.min_y < it.max_y);
  endfunction

  function automatic pixel_result_t scan_pixel();
    pixel_result_t r;
    longint px, py, dx, dy, q, num, den, shade;
    logic lit;
    r = '0;
    if (!scan_on) begin
      r.done = 1'b1;
      return r;
    end
    px = longint'(scan_col) * (longint'(1) << FRAC);
    py = longint'(scan_row) * (longint'(1) << FRAC);
    lit = edge_side(tri_v[2], tri_v[3], tri_v[4], tri_v[5], px, py) >= 0 &&
          edge_side(tri_v[4], tri_v[5], tri_v[0], tri_v[1], px, py) >= 0 &&
          edge_side(tri_v[0], tri_v[1], tri_v[2], tri_v[3], px, py) >= 0 &&
          scan_col < scr_w && scan_row < scr_h &&
          int'(scan_col) < MAX_SCREEN && int'(scan_row) < MAX_SCREEN;
    if (lit) begin
      dx = tri_v[4] - px;
      dy = tri_v[5] - py;
      q = dx * dx + dy * dy;
      num = longint'(glow) << (2 * FRAC);
      den = q * 256;
      if (q == 0 || num >= den) shade = 255;
      else shade = (num * 255) / den;
      r.color = {4{shade[7:0]}};
    end
    r.we = lit;
    r.x = scan_col[11:0];
    r.y = scan_row[11:0];
    scan_row = scan_row + 13'd1;
    if (scan_row >= box_hi_y) begin
      scan_row = box_lo_y;
      scan_col = scan_col + 13'd1;
      if (scan_col >= box_hi_x) scan_on = 1'b0;
    end
    r.done = !scan_on;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 30) $display("mismatch at cycle %0d: %s", cycle, what);
    mismatches++;
  endtask

  task automatic check_pixel(pixel_result_t got);
    pixel_result_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected item x=%0d y=%0d", got.x, got.y));
      return;
    end
    want = pending_pixels.pop_front();
    if (got.we !== want.we)
      report_mismatch($sformatf("write_enable %b want %b", got.we, want.we));
    if (got.x !== want.x)
      report_mismatch($sformatf("pixel_x %0d want %0d", got.x, want.x));
    if (got.y !== want.y)
      report_mismatch($sformatf("pixel_y %0d want %0d", got.y, want.y));
    if (got.color !== want.color)
      report_mismatch($sformatf("pixel_color %h want %h at (%0d,%0d)",
                                got.color, want.color, want.x, want.y));
    if (got.done !== want.done)
      report_mismatch($sformatf("done_res %b want %b", got.done, want.done));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (write_enable === 1'b1) n_lit++;
      check_pixel('{write_enable, pixel_x, pixel_y, pixel_color, done_res});
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_stall || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle,
               pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic take_item(raster_item_t it, logic typed, pixel_result_t want);
    pixel_result_t r;
    if (it.op == OP_LOAD) begin
      load_triangle(it);
      n_loads++;
    end else begin
      r = scan_pixel();
      pending_pixels.push_back(typed ? want : r);
      n_ticks++;
    end
  endtask

  task automatic send_item(raster_item_t it, logic typed, pixel_result_t want);
    int gap;
    gap = 0;
    if (!no_stall && $urandom_range(99) < 18) gap = $urandom_range(1, 24);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    vertex_a_x <= it.ax;
    vertex_a_y <= it.ay;
    vertex_b_x <= it.bx;
    vertex_b_y <= it.by;
    light_x <= it.cx;
    light_y <= it.cy;
    box_min_x <= it.min_x;
    box_max_x <= it.max_x;
    box_min_y <= it.min_y;
    box_max_y <= it.max_y;
    light_strength <= it.strength;
    do @(posedge clk); while (in_ready !== 1'b1);
    take_item(it, 1'b0, want);
  endtask

  task automatic send_checked(raster_item_t it, logic typed, pixel_result_t want);
    int gap;
    gap = 0;
    if (!no_stall && $urandom_range(99) < 18) gap = $urandom_range(1, 24);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    vertex_a_x <= it.ax;
    vertex_a_y <= it.ay;
    vertex_b_x <= it.bx;
    vertex_b_y <= it.by;
    light_x <= it.cx;
    light_y <= it.cy;
    box_min_x <= it.min_x;
    box_max_x <= it.max_x;
    box_min_y <= it.min_y;
    box_max_y <= it.max_y;
    light_strength <= it.strength;
    do @(posedge clk); while (in_ready !== 1'b1);
    take_item(it, typed, want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(logic [12:0] w, logic [12:0] h);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    n_settings++;
  endtask

  function automatic logic [12:0] box_edge();
    if ($urandom_range(9) == 0) return 13'd4096;
    return 13'($urandom_range(0, 4096));
  endfunction

  function automatic raster_item_t random_payload(logic op);
    raster_item_t it;
    it.op = op;
    it.ax = 16'($urandom);
    it.ay = 16'($urandom);
    it.bx = 16'($urandom);
    it.by = 16'($urandom);
    it.cx = 16'($urandom);
    it.cy = 16'($urandom);
    it.min_x = box_edge();
    it.max_x = box_edge();
    it.min_y = box_edge();
    it.max_y = box_edge();
    it.strength = 24'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] near_coord(int c, int span);
    int v;
    v = c - span + int'($urandom_range(0, 2 * span));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic raster_item_t scene_load(int x0, int y0, int w, int h);
    raster_item_t it;
    int mx, my, span;
    logic [15:0] tx, ty;
    mx = (2 * x0 + w) * 8;
    my = (2 * y0 + h) * 8;
    span = (w + h) * 16 + 48;
    it.op = OP_LOAD;
    it.ax = near_coord(mx, span);
    it.ay = near_coord(my, span);
    it.bx = near_coord(mx, span);
    it.by = near_coord(my, span);
    it.cx = near_coord(mx, span / 2);
    it.cy = near_coord(my, span / 2);
    if ($urandom_range(1) == 1) begin
      tx = it.ax; ty = it.ay;
      it.ax = it.bx; it.ay = it.by;
      it.bx = tx; it.by = ty;
    end
    it.min_x = 13'(x0);
    it.max_x = 13'(x0 + w);
    it.min_y = 13'(y0);
    it.max_y = 13'(y0 + h);
    case ($urandom_range(3))
      0: it.strength = 24'($urandom_range(0, 1 << 16));
      1: it.strength = 24'($urandom);
      2: it.strength = 24'($urandom_range(0, 255));
      default: it.strength = 24'($urandom_range(0, 1 << 12));
    endcase
    return it;
  endfunction

  function automatic int pick_origin(int screen, int extent);
    int o;
    case ($urandom_range(3))
      0: o = $urandom_range(0, 20);
      1: o = screen - int'($urandom_range(0, 3));
      2: o = $urandom_range(0, 4096 - extent);
      default: o = $urandom_range(0, 2040);
    endcase
    if (o < 0) o = 0;
    if (o > 4096 - extent) o = 4096 - extent;
    return o;
  endfunction

  task automatic random_scans(int n);
    int sent, w, h, area, nt, r;
    raster_item_t ld;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 12) begin
        send_item(random_payload(1'($urandom)), 1'b0, IDLE_TICK);
        sent++;
      end else begin
        w = $urandom_range(1, 5);
        h = $urandom_range(1, 5);
        ld = scene_load(pick_origin(int'(scr_w), w), pick_origin(int'(scr_h), h), w, h);
        area = w * h;
        if ($urandom_range(19) == 0) begin
          if ($urandom_range(1) == 1) ld.max_x = ld.min_x;
          else ld.max_y = 13'($urandom_range(0, int'(ld.min_y)));
          area = 0;
        end
        send_item(ld, 1'b0, IDLE_TICK);
        sent++;
        r = $urandom_range(99);
        if (area == 0) nt = $urandom_range(0, 2);
        else if (r < 15) nt = $urandom_range(0, area);
        else if (r < 30) nt = area + int'($urandom_range(1, 3));
        else nt = area;
        repeat (nt) begin
          send_item(random_payload(OP_TICK), 1'b0, IDLE_TICK);
          sent++;
        end
      end
    end
  endtask

  function automatic plan_row_t load_row(int ax, int ay, int bx, int by, int cx, int cy,
                                         int x0, int x1, int y0, int y1, int s);
    plan_row_t p;
    p = '0;
    p.item.op = OP_LOAD;
    p.item.ax = 16'(ax);
    p.item.ay = 16'(ay);
    p.item.bx = 16'(bx);
    p.item.by = 16'(by);
    p.item.cx = 16'(cx);
    p.item.cy = 16'(cy);
    p.item.min_x = 13'(x0);
    p.item.max_x = 13'(x1);
    p.item.min_y = 13'(y0);
    p.item.max_y = 13'(y1);
    p.item.strength = 24'(s);
    return p;
  endfunction

  function automatic plan_row_t tick_row(logic typed, pixel_result_t want);
    plan_row_t p;
    p = '0;
    p.item.op = OP_TICK;
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  initial begin
    plan_row_t plan [$];
    raster_item_t ld;
    scr_w = SCREEN_WIDTH_RST;
    scr_h = SCREEN_HEIGHT_RST;
    load_triangle('0);

    // idle after reset, zero distance, box past its end
    plan.push_back(tick_row(1'b1, IDLE_TICK));
    plan.push_back(load_row(0, 0, 32767, 0, 32, 32, 2, 3, 2, 3, 0));
    plan.push_back(tick_row(1'b1, '{1'b1, 12'd2, 12'd2, 32'hFFFF_FFFF, 1'b1}));
    plan.push_back(tick_row(1'b1, IDLE_TICK));
    // empty box
    plan.push_back(load_row(-32768, -32768, -32768, -32768, -32768, -32768,
                            4096, 0, 4096, 4096, 24'hFF_FFFF));
    plan.push_back(tick_row(1'b1, IDLE_TICK));
    // last pixel of the coordinate space, off screen
    plan.push_back(load_row(-32768, -32768, 32767, -32768, 32767, 32767,
                            4095, 4096, 4095, 4096, 24'hFF_FFFF));
    plan.push_back(tick_row(1'b1, '{1'b0, 12'd4095, 12'd4095, 32'd0, 1'b1}));
    // small scan cut short by a new load
    plan.push_back(load_row(-160, -160, 960, -80, 56, 20, 0, 3, 0, 3, 2048));
    repeat (4) plan.push_back(tick_row(1'b0, IDLE_TICK));
    // scan across the right and bottom screen edges
    plan.push_back(load_row(-32768, -32768, 32767, -32768, 32767, 32767,
                            799, 801, 599, 601, 24'hFF_FFFF));
    repeat (5) plan.push_back(tick_row(1'b0, IDLE_TICK));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_checked(plan[i].item, plan[i].typed, plan[i].want);

    drain();
    set_screen(13'd4096, 13'd4096);
    random_scans(220);

    // receiver holds off while ticks keep coming
    drain();
    set_screen(13'd1, 13'd1);
    ld = scene_load(0, 0, 8, 8);
    send_item(ld, 1'b0, IDLE_TICK);
    hold_requests = hold_requests + 1;
    repeat (60) send_item(random_payload(OP_TICK), 1'b0, IDLE_TICK);
    drain();
    random_scans(150);

    drain();
    no_stall = 1'b1;
    set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    random_scans(200);
    no_stall = 1'b0;

    drain();
    set_screen(13'd13, 13'd7);
    random_scans(180);

    drain();
    set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
    random_scans(150);

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d triangle loads and %0d pixel ticks, %0d lit writes,",
             n_loads, n_ticks, n_lit);
    $display("over %0d screen sizes with stalls on both sides, %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
